@@ hdl/bsr_pkg.sv @@
// Shared types and constants of the byte stream reassembler.
package bsr_pkg;

    // Width of byte counts: capacity, buffered, held and per-item result counts
    localparam int CNT_W = 7;

    // Default ring depth
    localparam int DEFAULT_DEPTH = 64;

    // Most bytes released by one request
    localparam int MAX_RESULTS = 64;

    // Capacity register value after reset
    localparam logic [CNT_W-1:0] WC_RESET = 7'd64;

    // Request kinds carried on the input tuser
    typedef enum logic [1:0] {
        CMD_DATA = 2'd0,
        CMD_END  = 2'd1,
        CMD_POP  = 2'd2
    } cmd_t;

    // One ring entry: occupied flag and stored byte
    typedef struct packed {
        logic       valid;
        logic [7:0] data;
    } slot_t;

endpackage

@@ hdl/bsr_slot_ram.sv @@
// Single-port ring memory of the reassembler with registered read data.
module bsr_slot_ram
    import bsr_pkg::*;
#(
    parameter int WINDOW_DEPTH = DEFAULT_DEPTH
)
(
    input  logic                            clk,
    input  logic                            en,
    input  logic                            we,
    input  logic [$clog2(WINDOW_DEPTH)-1:0] addr,
    input  slot_t                           wdata,
    output slot_t                           rdata
);

    slot_t mem [WINDOW_DEPTH];
    slot_t rdata_reg;

    // Write on we, otherwise read; hold read data between reads
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata_reg <= mem[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ hdl/byte_stream_reassembler_unit.sv @@
// Top level of the byte stream reassembler: sequencer, window check and output register.
//
//  channel  | direction | handshake               | payload
//  ---------+-----------+-------------------------+--------------------------------------
//  s_axis   | in        | s_axis_tvalid/tready    | tdata, tuser (kind), tlast (final)
//  m_axis   | out       | m_axis_tvalid/tready    | tdata, tuser (byte flag), tlast (run end)
//  cfg      | in        | cfg_valid/cfg_ready     | cfg_data (window capacity)
//
// After reset the ring is swept clear, slot by slot, before the first request is taken.
// A request is taken only in the idle state, so the next one waits until the last is through;
// the single ring port, read then written once per released or stored byte, sets the pace.
// A run of released bytes stops at an empty slot, a full downstream or 64 bytes.
// One finished result waits in the output register while the next request is taken;
// a full output register stalls the sequencer only when it has another result to give.
module byte_stream_reassembler_unit
    import bsr_pkg::*;
#(
    parameter int WINDOW_DEPTH = DEFAULT_DEPTH
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [79:0]      s_axis_tdata,   // stream_index[63:0], byte_value[71:64],
                                             // pop_count[78:72], zero[79]
    input  logic [1:0]       s_axis_tuser,   // cmd[1:0]
    input  logic             s_axis_tlast,   // is_final
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [15:0]      m_axis_tdata,   // out_byte[7:0], stream_closed[8],
                                             // pending_count[15:9]
    output logic [0:0]       m_axis_tuser,   // byte_valid[0]
    output logic             m_axis_tlast,   // run_last
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [CNT_W-1:0] cfg_data
);

    localparam int SW = $clog2(WINDOW_DEPTH);
    localparam int DEPTH_CAP = (WINDOW_DEPTH < 127) ? WINDOW_DEPTH : 127;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC,
        S_SLOT,
        S_WR,
        S_FLUSH_RD,
        S_FLUSH_CHK,
        S_FINISH
    } state_t;

    state_t           state_reg, state_next;
    cmd_t             cmd_reg, cmd_next;
    logic [63:0]      idx_reg, idx_next;
    logic [7:0]       val_reg, val_next;
    logic             fin_reg, fin_next;
    logic [CNT_W-1:0] pop_reg, pop_next;

    logic [63:0]      ne_reg, ne_next;
    logic [SW-1:0]    head_reg, head_next;
    logic [CNT_W-1:0] db_reg, db_next;
    logic [CNT_W-1:0] held_reg, held_next;
    logic             end_seen_reg, end_seen_next;
    logic [63:0]      end_pos_reg, end_pos_next;
    logic [CNT_W-1:0] wc_reg, wc_next;

    logic [SW-1:0]    off_reg, off_next;
    logic [SW-1:0]    slot_reg, slot_next;
    logic [CNT_W-1:0] n_reg, n_next;
    logic             pend_full_reg, pend_full_next;
    logic [7:0]       pend_byte_reg, pend_byte_next;
    logic [SW-1:0]    clr_reg, clr_next;

    logic             out_valid_reg, out_valid_next;
    logic [15:0]      out_data_reg, out_data_next;
    logic             out_user_reg, out_user_next;
    logic             out_last_reg, out_last_next;

    logic             mem_en;
    logic             mem_we;
    logic [SW-1:0]    mem_addr;
    slot_t            mem_wdata;
    slot_t            mem_rdata;

    logic [CNT_W-1:0] cap;
    logic [CNT_W-1:0] avail;
    logic [64:0]      diff;
    logic             in_window;
    logic             closed_now;
    logic             out_free;
    logic [SW:0]      slot_sum;
    logic [SW-1:0]    slot_wrap;
    logic [SW-1:0]    head_inc;
    logic             push;
    logic             push_valid;
    logic [7:0]       push_byte;
    logic             push_last;

    bsr_slot_ram #(
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_ram (
        .clk   (clk),
        .en    (mem_en),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    // Effective capacity and free window space
    always_comb
    begin
        if (32'(wc_reg) < WINDOW_DEPTH)
        begin
            cap = wc_reg;
        end
        else
        begin
            cap = CNT_W'(DEPTH_CAP);
        end
        avail = (cap > db_reg) ? (cap - db_reg) : '0;
    end

    // Window check of the stored index against the expected index
    assign diff      = {1'b0, idx_reg} - {1'b0, ne_reg};
    assign in_window = !diff[64] && (diff[63:0] < 64'(avail));

    // Ring slot of an accepted byte
    assign slot_sum  = {1'b0, head_reg} + {1'b0, off_reg};
    assign slot_wrap = (slot_sum >= (SW+1)'(WINDOW_DEPTH)) ?
                       SW'(slot_sum - (SW+1)'(WINDOW_DEPTH)) : SW'(slot_sum);
    assign head_inc  = (head_reg == SW'(WINDOW_DEPTH - 1)) ? '0 : head_reg + SW'(1);

    assign closed_now = end_seen_reg && (ne_reg == end_pos_reg);
    assign out_free   = !out_valid_reg || m_axis_tready;

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        idx_next       = idx_reg;
        val_next       = val_reg;
        fin_next       = fin_reg;
        pop_next       = pop_reg;
        ne_next        = ne_reg;
        head_next      = head_reg;
        db_next        = db_reg;
        held_next      = held_reg;
        end_seen_next  = end_seen_reg;
        end_pos_next   = end_pos_reg;
        wc_next        = wc_reg;
        off_next       = off_reg;
        slot_next      = slot_reg;
        n_next         = n_reg;
        pend_full_next = pend_full_reg;
        pend_byte_next = pend_byte_reg;
        clr_next       = clr_reg;

        mem_en     = 1'b0;
        mem_we     = 1'b0;
        mem_addr   = head_reg;
        mem_wdata  = '0;
        push       = 1'b0;
        push_valid = 1'b0;
        push_byte  = '0;
        push_last  = 1'b0;

        // Take a capacity write at any time
        if (cfg_valid)
        begin
            wc_next = cfg_data;
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                mem_en   = 1'b1;
                mem_we   = 1'b1;
                mem_addr = clr_reg;
                clr_next = clr_reg + SW'(1);
                if (clr_reg == SW'(WINDOW_DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    cmd_next   = cmd_t'(s_axis_tuser);
                    idx_next   = s_axis_tdata[63:0];
                    val_next   = s_axis_tdata[71:64];
                    pop_next   = s_axis_tdata[78:72];
                    fin_next   = s_axis_tlast;
                    state_next = S_EXEC;
                end
            end

            S_EXEC:
            begin
                n_next         = '0;
                pend_full_next = 1'b0;
                case (cmd_reg)
                    CMD_DATA:
                    begin
                        if (fin_reg)
                        begin
                            end_seen_next = 1'b1;
                            end_pos_next  = idx_reg + 64'd1;
                        end
                        off_next   = diff[SW-1:0];
                        state_next = in_window ? S_SLOT : S_FLUSH_RD;
                    end
                    CMD_END:
                    begin
                        end_seen_next = 1'b1;
                        end_pos_next  = idx_reg;
                        state_next    = S_FLUSH_RD;
                    end
                    CMD_POP:
                    begin
                        db_next    = db_reg - ((pop_reg < db_reg) ? pop_reg : db_reg);
                        state_next = S_FLUSH_RD;
                    end
                    default:
                    begin
                        state_next = S_FINISH;
                    end
                endcase
            end

            // Read the target slot to learn whether it is already held
            S_SLOT:
            begin
                mem_en     = 1'b1;
                mem_addr   = slot_wrap;
                slot_next  = slot_wrap;
                state_next = S_WR;
            end

            // Store the byte; count it if the slot was empty
            S_WR:
            begin
                mem_en         = 1'b1;
                mem_we         = 1'b1;
                mem_addr       = slot_reg;
                mem_wdata.valid = 1'b1;
                mem_wdata.data  = val_reg;
                if (!mem_rdata.valid)
                begin
                    held_next = held_reg + CNT_W'(1);
                end
                state_next = S_FLUSH_RD;
            end

            // Fetch the head slot while there is room downstream and fewer than MAX_RESULTS bytes are released
            S_FLUSH_RD:
            begin
                if ((n_reg < CNT_W'(MAX_RESULTS)) && (db_reg < cap))
                begin
                    mem_en     = 1'b1;
                    mem_addr   = head_reg;
                    state_next = S_FLUSH_CHK;
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end

            // Release the head byte; hand the previous one to the output
            S_FLUSH_CHK:
            begin
                if (!mem_rdata.valid)
                begin
                    state_next = S_FINISH;
                end
                else if (!pend_full_reg || out_free)
                begin
                    if (pend_full_reg)
                    begin
                        push       = 1'b1;
                        push_valid = 1'b1;
                        push_byte  = pend_byte_reg;
                    end
                    pend_full_next = 1'b1;
                    pend_byte_next = mem_rdata.data;
                    mem_en         = 1'b1;
                    mem_we         = 1'b1;
                    mem_addr       = head_reg;
                    head_next      = head_inc;
                    ne_next        = ne_reg + 64'd1;
                    db_next        = db_reg + CNT_W'(1);
                    held_next      = held_reg - CNT_W'(1);
                    n_next         = n_reg + CNT_W'(1);
                    state_next     = S_FLUSH_RD;
                end
            end

            // Give the last result of the request, or a status result
            S_FINISH:
            begin
                if (out_free)
                begin
                    push           = 1'b1;
                    push_valid     = pend_full_reg;
                    push_byte      = pend_full_reg ? pend_byte_reg : 8'd0;
                    push_last      = 1'b1;
                    pend_full_next = 1'b0;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output register: load on push, drop once taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_user_next  = out_user_reg;
        out_last_next  = out_last_reg;
        if (push)
        begin
            out_valid_next = 1'b1;
            out_data_next  = {held_reg, closed_now, push_byte};
            out_user_next  = push_valid;
            out_last_next  = push_last;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Hold state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            cmd_reg       <= CMD_DATA;
            idx_reg       <= '0;
            val_reg       <= '0;
            fin_reg       <= 1'b0;
            pop_reg       <= '0;
            ne_reg        <= '0;
            head_reg      <= '0;
            db_reg        <= '0;
            held_reg      <= '0;
            end_seen_reg  <= 1'b0;
            end_pos_reg   <= '0;
            wc_reg        <= WC_RESET;
            off_reg       <= '0;
            slot_reg      <= '0;
            n_reg         <= '0;
            pend_full_reg <= 1'b0;
            pend_byte_reg <= '0;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
            out_user_reg  <= 1'b0;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cmd_reg       <= cmd_next;
            idx_reg       <= idx_next;
            val_reg       <= val_next;
            fin_reg       <= fin_next;
            pop_reg       <= pop_next;
            ne_reg        <= ne_next;
            head_reg      <= head_next;
            db_reg        <= db_next;
            held_reg      <= held_next;
            end_seen_reg  <= end_seen_next;
            end_pos_reg   <= end_pos_next;
            wc_reg        <= wc_next;
            off_reg       <= off_next;
            slot_reg      <= slot_next;
            n_reg         <= n_next;
            pend_full_reg <= pend_full_next;
            pend_byte_reg <= pend_byte_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
            out_data_reg  <= out_data_next;
            out_user_reg  <= out_user_next;
            out_last_reg  <= out_last_next;
        end
    end

    assign s_axis_tready = (state_reg == S_IDLE);
    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule
